@@ rtl/vt4_pkg.sv @@
// Shared types, widths and constants for the 4x4 vector transform.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package vt4_pkg;

    localparam int COEF_WIDTH  = 16;                       // coefficient bits used per lane
    localparam int DATA_WIDTH  = 32;                       // vector component bits used
    localparam int COEF_FRAC   = COEF_WIDTH - 4;           // fraction bits of a coefficient
    localparam int LANE_WIDTH  = 16;                       // lane pitch inside a row register
    localparam int ROW_WIDTH   = 64;
    localparam int FIELD_WIDTH = 32;                       // port width of a component
    localparam int NUM_COMP    = 4;
    localparam int PROD_WIDTH  = COEF_WIDTH + DATA_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;           // room for four products and rounding
    localparam int QUEUE_DEPTH = 8;                        // output queue entries
    localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_WIDTH   = 2;

    localparam logic OP_FULL = 1'b0;
    localparam logic OP_DIR  = 1'b1;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_ROW_0 = 2'd0,
        REG_ROW_1 = 2'd1,
        REG_ROW_2 = 2'd2,
        REG_ROW_3 = 2'd3
    } cfg_reg_t;

    typedef logic        [ROW_WIDTH-1:0]  row_t;
    typedef row_t        [NUM_COMP-1:0]   rows_t;
    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;

    // identity matrix, Q4.12 one on the diagonal
    localparam row_t ROW_0_RESET = 64'd4096;
    localparam row_t ROW_1_RESET = 64'd268435456;
    localparam row_t ROW_2_RESET = 64'd17592186044416;
    localparam row_t ROW_3_RESET = 64'd1152921504606846976;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam sum_t  ROUND_HALF = sum_t'(1) <<< (COEF_FRAC - 1);

    localparam logic signed [FIELD_WIDTH-1:0] OUT_MAX = FIELD_WIDTH'(DATA_MAX);
    localparam logic signed [FIELD_WIDTH-1:0] OUT_MIN = FIELD_WIDTH'(DATA_MIN);

    typedef struct packed {
        logic                     valid;
        logic                     op;
        data_t [NUM_COMP-1:0]     vec;
    } vin_t;

    typedef struct packed {
        logic                               valid;
        prod_t [NUM_COMP-1:0][NUM_COMP-1:0] prod;
    } vprod_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] x;
        logic [FIELD_WIDTH-1:0] y;
        logic [FIELD_WIDTH-1:0] z;
        logic [FIELD_WIDTH-1:0] w;
        logic                   sat;
    } result_t;

    // signed coefficient of column c taken from a row register
    function automatic coef_t coef_lane(input row_t r, input int c);
        coef_lane = coef_t'(r[LANE_WIDTH*c +: COEF_WIDTH]);
    endfunction

endpackage

`default_nettype wire

@@ rtl/vector_transform_4x4.sv @@
// Top level of the 4x4 fixed-point vector transform: matrix registers, input stage,
// credit counter and the pipeline. Depends on vt4_pkg, vt4_mult, vt4_accum, vt4_fifo.
//
//   channel   direction  handshake             payload
//   s_        in         s_valid / s_ready     s_op, s_in_x, s_in_y, s_in_z, s_in_w
//   m_        out        m_valid / m_ready     m_out_x .. m_out_w, m_saturated
//   cfg_      in         cfg_wr_en (no wait)   cfg_index, cfg_wdata
//
// One vector per cycle sustained while s_ready is high. A transfer passes the input,
// product, sum and round stages, then the output queue, before it reaches m_valid.
// The pipeline never stalls: an eight-entry output queue takes every result, and s_ready
// drops only while eight vectors are accepted but not yet handed on, so m_ready never
// reaches s_ready through logic. Synchronous active-low reset loads the identity matrix
// and empties the pipeline and the queue; no clearing pass is needed.
`default_nettype none

module vector_transform_4x4 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [31:0] s_in_x,
    input  wire logic [31:0] s_in_y,
    input  wire logic [31:0] s_in_z,
    input  wire logic [31:0] s_in_w,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_out_x,
    output logic [31:0]      m_out_y,
    output logic [31:0]      m_out_z,
    output logic [31:0]      m_out_w,
    output logic             m_saturated
);

    vt4_pkg::rows_t                 rows_reg;
    logic                           in_valid_reg;
    logic                           in_op_reg;
    vt4_pkg::data_t [3:0]           in_vec_reg;
    vt4_pkg::vin_t                  vin;
    vt4_pkg::vprod_t                vprod;
    logic                           res_valid;
    vt4_pkg::result_t               res;
    vt4_pkg::result_t               out_data;
    logic [vt4_pkg::CNT_WIDTH-1:0]  credit_reg;
    logic [vt4_pkg::CNT_WIDTH-1:0]  credit_next;
    logic                           s_xfer;
    logic                           m_xfer;

    // ------------------------------------------------------------------
    // Matrix registers: written by the user only while the block is idle; not enforced.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg[0] <= vt4_pkg::ROW_0_RESET;
            rows_reg[1] <= vt4_pkg::ROW_1_RESET;
            rows_reg[2] <= vt4_pkg::ROW_2_RESET;
            rows_reg[3] <= vt4_pkg::ROW_3_RESET;
        end else if (cfg_wr_en) begin
            case (vt4_pkg::cfg_reg_t'(cfg_index))
                vt4_pkg::REG_ROW_0: rows_reg[0] <= cfg_wdata;
                vt4_pkg::REG_ROW_1: rows_reg[1] <= cfg_wdata;
                vt4_pkg::REG_ROW_2: rows_reg[2] <= cfg_wdata;
                vt4_pkg::REG_ROW_3: rows_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Credit counter: vectors accepted and not yet transferred out.
    // Hold s_ready low once the queue could be filled by work in flight.
    // ------------------------------------------------------------------
    assign s_ready = (credit_reg < vt4_pkg::CNT_WIDTH'(vt4_pkg::QUEUE_DEPTH));
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;

    always_comb begin
        credit_next = credit_reg;
        if (s_xfer && !m_xfer) begin
            credit_next = credit_reg + 1'b1;
        end else if (!s_xfer && m_xfer) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg   <= '0;
            in_valid_reg <= 1'b0;
        end else begin
            credit_reg   <= credit_next;
            in_valid_reg <= s_xfer;
        end
    end

    // Input stage: keep only the low DATA_WIDTH bits of each component.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_op_reg     <= s_op;
            in_vec_reg[0] <= vt4_pkg::data_t'(s_in_x[vt4_pkg::DATA_WIDTH-1:0]);
            in_vec_reg[1] <= vt4_pkg::data_t'(s_in_y[vt4_pkg::DATA_WIDTH-1:0]);
            in_vec_reg[2] <= vt4_pkg::data_t'(s_in_z[vt4_pkg::DATA_WIDTH-1:0]);
            in_vec_reg[3] <= vt4_pkg::data_t'(s_in_w[vt4_pkg::DATA_WIDTH-1:0]);
        end
    end

    assign vin.valid = in_valid_reg;
    assign vin.op    = in_op_reg;
    assign vin.vec   = in_vec_reg;

    // ------------------------------------------------------------------
    // Products, sums, rounding, then the output queue.
    // ------------------------------------------------------------------
    vt4_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .vin     (vin),
        .rows    (rows_reg),
        .vprod   (vprod)
    );

    vt4_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .vprod     (vprod),
        .res_valid (res_valid),
        .res       (res)
    );

    vt4_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_valid (m_valid),
        .rd_en    (m_ready),
        .rd_data  (out_data)
    );

    assign m_out_x     = out_data.x;
    assign m_out_y     = out_data.y;
    assign m_out_z     = out_data.z;
    assign m_out_w     = out_data.w;
    assign m_saturated = out_data.sat;

endmodule

`default_nettype wire

@@ rtl/vt4_mult.sv @@
// Coefficient selection and the sixteen registered products.
// Depends on vt4_pkg.
`default_nettype none

module vt4_mult (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire vt4_pkg::vin_t  vin,
    input  wire vt4_pkg::rows_t rows,
    output vt4_pkg::vprod_t     vprod
);

    vt4_pkg::coef_t [vt4_pkg::NUM_COMP-1:0][vt4_pkg::NUM_COMP-1:0] cm;
    logic            valid_reg;
    vt4_pkg::prod_t [vt4_pkg::NUM_COMP-1:0][vt4_pkg::NUM_COMP-1:0] prod_reg;

    // direction mode: transposed upper 3x3, zero in the fourth row and column
    always_comb begin
        for (int i = 0; i < vt4_pkg::NUM_COMP; i++) begin
            for (int k = 0; k < vt4_pkg::NUM_COMP; k++) begin
                if (vin.op == vt4_pkg::OP_DIR) begin
                    cm[i][k] = (i < vt4_pkg::NUM_COMP - 1 && k < vt4_pkg::NUM_COMP - 1)
                             ? vt4_pkg::coef_lane(rows[k], i) : '0;
                end else begin
                    cm[i][k] = vt4_pkg::coef_lane(rows[i], k);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= vin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < vt4_pkg::NUM_COMP; i++) begin
            for (int k = 0; k < vt4_pkg::NUM_COMP; k++) begin
                prod_reg[i][k] <= $signed(cm[i][k]) * $signed(vin.vec[k]);
            end
        end
    end

    assign vprod.valid = valid_reg;
    assign vprod.prod  = prod_reg;

endmodule

`default_nettype wire

@@ rtl/vt4_accum.sv @@
// Row sums, then round to nearest and saturate, one register stage each.
// Depends on vt4_pkg.
`default_nettype none

module vt4_accum (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire vt4_pkg::vprod_t vprod,
    output logic                 res_valid,
    output vt4_pkg::result_t     res
);

    logic                                 sum_valid_reg;
    vt4_pkg::sum_t [vt4_pkg::NUM_COMP-1:0] sum_reg;
    vt4_pkg::sum_t [vt4_pkg::NUM_COMP-1:0] sum_next;
    logic                                 res_valid_reg;
    vt4_pkg::result_t                     res_reg;
    vt4_pkg::result_t                     res_next;
    logic [vt4_pkg::FIELD_WIDTH-1:0]      comp [vt4_pkg::NUM_COMP];
    logic [vt4_pkg::NUM_COMP-1:0]         ovf;

    always_comb begin
        for (int i = 0; i < vt4_pkg::NUM_COMP; i++) begin
            sum_next[i] = vt4_pkg::sum_t'(vprod.prod[i][0]) + vt4_pkg::sum_t'(vprod.prod[i][1])
                        + vt4_pkg::sum_t'(vprod.prod[i][2]) + vt4_pkg::sum_t'(vprod.prod[i][3]);
        end
    end

    // add half, floor, clamp to the data range
    always_comb begin
        vt4_pkg::sum_t  q;
        vt4_pkg::data_t r;
        for (int i = 0; i < vt4_pkg::NUM_COMP; i++) begin
            q = (sum_reg[i] + vt4_pkg::ROUND_HALF) >>> vt4_pkg::COEF_FRAC;
            ovf[i] = !((q[vt4_pkg::SUM_WIDTH-1:vt4_pkg::DATA_WIDTH-1] == '0)
                    || (q[vt4_pkg::SUM_WIDTH-1:vt4_pkg::DATA_WIDTH-1] == '1));
            if (ovf[i]) begin
                r = q[vt4_pkg::SUM_WIDTH-1] ? vt4_pkg::DATA_MIN : vt4_pkg::DATA_MAX;
            end else begin
                r = vt4_pkg::data_t'(q[vt4_pkg::DATA_WIDTH-1:0]);
            end
            comp[i] = vt4_pkg::FIELD_WIDTH'(r);
        end
        res_next.x   = comp[0];
        res_next.y   = comp[1];
        res_next.z   = comp[2];
        res_next.w   = comp[3];
        res_next.sat = |ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            sum_valid_reg <= vprod.valid;
            res_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ rtl/vt4_fifo.sv @@
// Output queue that absorbs the pipeline while the result side stalls.
// Depends on vt4_pkg.
`default_nettype none

module vt4_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire vt4_pkg::result_t wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_en,
    output vt4_pkg::result_t      rd_data
);

    vt4_pkg::result_t                mem_reg [vt4_pkg::QUEUE_DEPTH];
    logic [vt4_pkg::PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [vt4_pkg::PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [vt4_pkg::CNT_WIDTH-1:0]   cnt_reg;
    logic [vt4_pkg::CNT_WIDTH-1:0]   cnt_next;
    logic                            pop;

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_en;

    always_comb begin
        cnt_next = cnt_reg;
        if (wr_en && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!wr_en && pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vt4_checker.sv @@
// Port-level checks for vector_transform_4x4, attached by the bind at the end.
// Depends on vt4_pkg.
`default_nettype none

module vt4_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_out_x,
    input wire logic [31:0] m_out_y,
    input wire logic [31:0] m_out_z,
    input wire logic [31:0] m_out_w,
    input wire logic        m_saturated
);

    // reset empties the block and opens the input side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // a full credit window always has results waiting at the output
    a_backpressure_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked with no result waiting");

    // a clamped result shows at least one component on a bound
    a_sat_on_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_out_x == vt4_pkg::OUT_MAX || m_out_x == vt4_pkg::OUT_MIN ||
            m_out_y == vt4_pkg::OUT_MAX || m_out_y == vt4_pkg::OUT_MIN ||
            m_out_z == vt4_pkg::OUT_MAX || m_out_z == vt4_pkg::OUT_MIN ||
            m_out_w == vt4_pkg::OUT_MAX || m_out_w == vt4_pkg::OUT_MIN)
        else $error("saturated flag without a clamped component");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
            && $stable(m_out_z) && $stable(m_out_w) && $stable(m_saturated))
        else $error("result changed while stalled");

endmodule

bind vector_transform_4x4 vt4_checker u_vt4_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_x     (m_out_x),
    .m_out_y     (m_out_y),
    .m_out_z     (m_out_z),
    .m_out_w     (m_out_w),
    .m_saturated (m_saturated)
);

`default_nettype wire

@@ verif/vector_transform_4x4_test.sv @@
// Self-checking testbench for vector_transform_4x4: directed and random vectors under
// several matrix settings, checked against an in-bench fixed-point transform model.
// Depends on rtl/vt4_pkg.sv and rtl/vector_transform_4x4.sv.

module vector_transform_4x4_test;

    timeunit 1ns;
    timeprecision 1ps;

    import vt4_pkg::*;

    // one input vector as offered on the s_ channel
    typedef struct packed {
        logic        op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
    } vector_item_t;

    typedef enum int {ROWS_FULL, ROWS_SMALL} row_style_t;

    localparam int HOLD_CYCLES = 250;     // long receiver hold-off, fills the output queue

    // ------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [63:0] cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_op        = 1'b0;
    logic [31:0] s_in_x      = '0;
    logic [31:0] s_in_y      = '0;
    logic [31:0] s_in_z      = '0;
    logic [31:0] s_in_w      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_out_x;
    logic [31:0] m_out_y;
    logic [31:0] m_out_z;
    logic [31:0] m_out_w;
    logic        m_saturated;

    vector_transform_4x4 u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_in_x      (s_in_x),
        .s_in_y      (s_in_y),
        .s_in_z      (s_in_z),
        .s_in_w      (s_in_w),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_out_w     (m_out_w),
        .m_saturated (m_saturated)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    row_t         matrix_rows [4] = '{ROW_0_RESET, ROW_1_RESET, ROW_2_RESET, ROW_3_RESET};
    vector_item_t vectors_pending [$];     // waiting for the driver
    result_t      expected_transforms [$]; // predicted, waiting for the monitor

    int  mismatch_count   = 0;
    int  transforms_seen  = 0;
    int  direction_count  = 0;
    int  clamped_count    = 0;
    int  matrix_settings  = 1;             // the reset identity counts as the first

    bit  sender_steady    = 1'b0;          // suppress sender gaps for a phase
    bit  receiver_steady  = 1'b0;          // suppress receiver stalls for a phase
    logic hold_start      = 1'b0;
    int   hold_left       = 0;
    int   send_gap        = 0;
    int   recv_stall      = 0;

    // ------------------------------------------------------------------
    // Transform model
    // ------------------------------------------------------------------

    // signed coefficient, row r column c, of the bench's copy of the matrix
    function automatic longint matrix_coef(input int r, input int c);
        logic signed [LANE_WIDTH-1:0] lane;
        lane = matrix_rows[r][LANE_WIDTH*c +: LANE_WIDTH];
        return longint'(lane);
    endfunction

    // round half up once, then clamp to the data range
    function automatic logic [31:0] round_clamp(input longint acc, output bit clamped);
        longint q;
        q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        clamped = 1'b0;
        if (q > longint'(DATA_MAX)) begin
            q = longint'(DATA_MAX);
            clamped = 1'b1;
        end else if (q < longint'(DATA_MIN)) begin
            q = longint'(DATA_MIN);
            clamped = 1'b1;
        end
        return q[31:0];
    endfunction

    function automatic result_t transform_vector(input vector_item_t item);
        longint      comp [4];
        longint      acc;
        logic [31:0] lanes [4];
        bit          clamped;
        bit          any_clamped;
        result_t     res;
        comp[0] = longint'(signed'(item.x));
        comp[1] = longint'(signed'(item.y));
        comp[2] = longint'(signed'(item.z));
        comp[3] = longint'(signed'(item.w));
        any_clamped = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            if (item.op == OP_FULL) begin
                for (int k = 0; k < 4; k++)
                    acc += matrix_coef(r, k) * comp[k];
            end else begin
                // direction: transposed upper 3x3, w dropped
                for (int k = 0; k < 3; k++)
                    acc += matrix_coef(k, r) * comp[k];
            end
            if (item.op == OP_DIR && r == 3) begin
                lanes[r] = '0;
            end else begin
                lanes[r] = round_clamp(acc, clamped);
                any_clamped |= clamped;
            end
        end
        res.x   = lanes[0];
        res.y   = lanes[1];
        res.z   = lanes[2];
        res.w   = lanes[3];
        res.sat = any_clamped;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 9))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic row_t random_row(input row_style_t style);
        row_t r;
        for (int c = 0; c < 4; c++) begin
            if (style == ROWS_FULL)
                r[LANE_WIDTH*c +: LANE_WIDTH] = 16'($urandom);
            else
                r[LANE_WIDTH*c +: LANE_WIDTH] = 16'($urandom_range(0, 16384) - 8192);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    task automatic add_vector(input logic op, input logic [31:0] x, y, z, w);
        vectors_pending.push_back('{op: op, x: x, y: y, z: z, w: w});
    endtask

    task automatic add_random_vectors(input int count);
        for (int i = 0; i < count; i++)
            add_vector($urandom_range(0, 1) ? OP_DIR : OP_FULL, random_component(),
                       random_component(), random_component(), random_component());
    endtask

    // the block must be idle here; keep the bench copy in step after the write edge
    task automatic write_row(input cfg_reg_t idx, input row_t value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        matrix_rows[idx] = value;
    endtask

    task automatic load_matrix(input row_t r0, r1, r2, r3);
        write_row(REG_ROW_0, r0);
        write_row(REG_ROW_1, r1);
        write_row(REG_ROW_2, r2);
        write_row(REG_ROW_3, r3);
        matrix_settings++;
    endtask

    // sample on the falling edge so nothing races the driver or monitor
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (vectors_pending.size() != 0 || s_valid || expected_transforms.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin : clock_gen
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Driver: pop the next pending vector once the previous one has been
    // transferred, with random gaps between items. Predict each vector at
    // the edge it is transferred, from the values the block actually saw.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        vector_item_t next_item;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_transforms.push_back(transform_vector(
                    '{op: s_op, x: s_in_x, y: s_in_y, z: s_in_z, w: s_in_w}));
                if (s_op == OP_DIR)
                    direction_count++;
            end
            // hold valid and payload until the transfer; otherwise advance
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (vectors_pending.size() != 0) begin
                    next_item = vectors_pending.pop_front();
                    s_op      <= next_item.op;
                    s_in_x    <= next_item.x;
                    s_in_y    <= next_item.y;
                    s_in_z    <= next_item.z;
                    s_in_w    <= next_item.w;
                    s_valid   <= 1'b1;
                    send_gap  <= sender_steady ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here and seen by the monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : hold_counter
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest prediction,
    // then decide whether to stall the next cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                transforms_seen++;
                if (expected_transforms.size() == 0) begin
                    $error("result transfer with no vector outstanding: %h %h %h %h sat %b",
                           m_out_x, m_out_y, m_out_z, m_out_w, m_saturated);
                    mismatch_count++;
                end else begin
                    want = expected_transforms.pop_front();
                    if (want.sat)
                        clamped_count++;
                    check_field("out_x", want.x, m_out_x);
                    check_field("out_y", want.y, m_out_y);
                    check_field("out_z", want.z, m_out_z);
                    check_field("out_w", want.w, m_out_w);
                    check_field("saturated", 32'(want.sat), 32'(m_saturated));
                end
            end
            if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                m_ready    <= 1'b0;
            end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
                recv_stall <= pick_gap();
                m_ready    <= 1'b0;
            end else begin
                m_ready <= (hold_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int phase_items;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset identity: zeros, extremes, mixed signs; w must be ignored in direction mode
        add_vector(OP_FULL, '0, '0, '0, '0);
        add_vector(OP_DIR,  '0, '0, '0, '0);
        add_vector(OP_FULL, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
        add_vector(OP_FULL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
        add_vector(OP_DIR,  DATA_MAX, DATA_MIN, 32'd1, DATA_MAX);
        add_vector(OP_FULL, 32'd1, '1, DATA_MAX, DATA_MIN);
        add_vector(OP_DIR,  '1, 32'd1, DATA_MIN, 32'h1234_5678);
        add_vector(OP_FULL, 32'h0001_8000, 32'hFFFE_8000, 32'h7FFF_0000, 32'h8001_0000);
        wait_idle();

        // Half on the diagonal and one off it: exact ties round towards plus infinity,
        // and direction mode shows the transpose
        load_matrix({16'h0000, 16'h0000, 16'h1000, 16'h0800},
                    {16'h0000, 16'h1000, 16'h0800, 16'h0000},
                    {16'h1000, 16'h0800, 16'h0000, 16'h0000},
                    {16'h0800, 16'h0000, 16'h0000, 16'h1000});
        add_vector(OP_FULL, 32'd1, '1, 32'd3, 32'hFFFF_FFFD);
        add_vector(OP_DIR,  32'd1, '1, 32'd3, 32'hFFFF_FFFD);
        add_vector(OP_FULL, DATA_MAX, DATA_MIN, '1, 32'd1);
        add_vector(OP_DIR,  DATA_MIN, DATA_MAX, 32'd1, '1);
        wait_idle();

        // Largest positive coefficients: clamp high and low
        load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        add_vector(OP_FULL, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
        add_vector(OP_DIR,  DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
        add_vector(OP_FULL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
        add_vector(OP_DIR,  DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
        add_vector(OP_FULL, 32'd1, 32'd1, 32'd1, 32'd1);
        wait_idle();

        // Most negative coefficients: min times min overflows upwards
        load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        add_vector(OP_FULL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
        add_vector(OP_DIR,  DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
        add_vector(OP_FULL, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
        add_vector(OP_DIR,  DATA_MAX, '0, '0, DATA_MIN);
        add_vector(OP_FULL, '1, '1, '1, '1);
        wait_idle();

        // Random phases, each under its own matrix
        for (int phase = 0; phase < 10; phase++) begin
            phase_items = 145;
            case (phase)
                2: begin
                    load_matrix('0, '0, '0, '0);
                    phase_items = 60;
                end
                4: begin
                    load_matrix({4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}});
                    phase_items = 60;
                end
                5: begin
                    load_matrix({4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}}, {4{16'h8000}});
                    phase_items = 60;
                end
                6: begin
                    load_matrix(ROW_0_RESET, ROW_1_RESET, ROW_2_RESET, ROW_3_RESET);
                    phase_items = 60;
                end
                1, 3, 8: load_matrix(random_row(ROWS_SMALL), random_row(ROWS_SMALL),
                                     random_row(ROWS_SMALL), random_row(ROWS_SMALL));
                default: load_matrix(random_row(ROWS_FULL), random_row(ROWS_FULL),
                                     random_row(ROWS_FULL), random_row(ROWS_SMALL));
            endcase
            sender_steady   = (phase == 0 || phase == 3 || phase == 7);
            receiver_steady = (phase == 4 || phase == 8);
            add_random_vectors(phase_items);

            // Hold the receiver off while the sender keeps offering, so the output
            // queue fills and s_ready drops
            if (phase == 0) begin
                @(posedge aclk);
                hold_start <= 1'b1;
                @(posedge aclk);
                hold_start <= 1'b0;
            end
            wait_idle();
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        // drain: allow the pipeline depth and a little more for stray results
        repeat (12) @(posedge aclk);
        if (expected_transforms.size() != 0) begin
            $error("%0d results never arrived", expected_transforms.size());
            mismatch_count += expected_transforms.size();
        end

        $display("Checked %0d transforms (%0d in direction mode, %0d clamped)",
                 transforms_seen, direction_count, clamped_count);
        $display("across %0d matrix settings with random sender gaps and receiver stalls",
                 matrix_settings);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Watchdog: several times the slowest legal run
    // ------------------------------------------------------------------
    initial begin : watchdog
        #2_000_000;
        $error("run timed out with %0d vectors pending and %0d results outstanding",
               vectors_pending.size(), expected_transforms.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
